// ===== hw/rtl/vdib_pkg.sv =====
package vdib_pkg;

  // Default sizes of the stores
  localparam int unsigned MaxPositions = 4096;
  localparam int unsigned MaxVertices  = 8192;
  localparam int unsigned UvSlots      = 8;

  // Fixed field widths
  localparam int unsigned PosW     = 12;
  localparam int unsigned AttrW    = 16;
  localparam int unsigned UvCountW = 4;
  localparam int unsigned OutIdxW  = 13;

  typedef struct packed {
    logic             new_mesh;
    logic [PosW-1:0]  pos_index;
    logic [AttrW-1:0] normal_index;
    logic [AttrW-1:0] uv_index_0;
    logic [AttrW-1:0] uv_index_1;
    logic [AttrW-1:0] uv_index_2;
    logic [AttrW-1:0] uv_index_3;
    logic [AttrW-1:0] uv_index_4;
    logic [AttrW-1:0] uv_index_5;
    logic [AttrW-1:0] uv_index_6;
    logic [AttrW-1:0] uv_index_7;
  } item_t;

  typedef struct packed {
    logic [OutIdxW-1:0] vertex_index;
    logic               created;
    logic               table_full;
  } result_t;

  // Select one texture slot of a corner
  function automatic logic [AttrW-1:0] uv_of(item_t it, logic [2:0] s);
    logic [AttrW-1:0] r;
    unique case (s)
      3'd0: r = it.uv_index_0;
      3'd1: r = it.uv_index_1;
      3'd2: r = it.uv_index_2;
      3'd3: r = it.uv_index_3;
      3'd4: r = it.uv_index_4;
      3'd5: r = it.uv_index_5;
      3'd6: r = it.uv_index_6;
      3'd7: r = it.uv_index_7;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/vertex_dedup_index_builder.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------
// in       | in_valid_i/in_ready_o | in_data_i  (corner index tuple)
// out      | out_valid_o/out_ready_i | out_data_o (vertex index, flags)
// cfg      | cfg_we_i              | cfg_wdata_i (uv_set_count)
//
// One corner at a time: it passes through S_KEY, S_HREQ and S_HEAD, then one S_CMP
// step per chain entry compared. With no match it goes on to S_APP, and to S_LINK
// as well when the vertex is appended behind an existing chain; a match skips
// S_APP and goes to S_OUT. The vertex memory walk compares one entry per cycle.
// After reset a clearing pass sweeps every entry of the head memory;
// no transaction is taken meanwhile. A stalled result waits in the output register.
module vertex_dedup_index_builder #(
  parameter int unsigned MAX_POSITIONS = vdib_pkg::MaxPositions,
  parameter int unsigned MAX_VERTICES  = vdib_pkg::MaxVertices,
  parameter int unsigned UV_SLOTS      = vdib_pkg::UvSlots
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vdib_pkg::item_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vdib_pkg::result_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [vdib_pkg::UvCountW-1:0]   cfg_wdata_i
);
  import vdib_pkg::*;

  localparam int unsigned KeyW  = $clog2(MAX_POSITIONS);
  localparam int unsigned VidxW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WideW = CntW + VidxW;

  typedef struct packed {
    logic [KeyW-1:0]                 key;
    logic [PosW-1:0]                 pos;
    logic [AttrW-1:0]                nrm;
    logic [UV_SLOTS-1:0][AttrW-1:0]  uv;
    logic                            link_ok;
    logic [VidxW-1:0]                link;
  } vert_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_KEY, S_HREQ, S_HEAD, S_CMP, S_APP, S_LINK, S_OUT
  } state_e;

  state_e            state_q;
  item_t             item_q;
  logic [CntW-1:0]   total_q;
  logic [UvCountW-1:0] uv_cnt_q;
  logic [KeyW-1:0]   clr_q;
  logic [VidxW-1:0]  cur_q;
  logic              first_q;
  logic              have_last_q;
  logic [VidxW-1:0]  last_q;
  vert_t             last_ent_q;
  logic [VidxW-1:0]  res_idx_q;
  logic              res_created_q;
  logic              res_full_q;
  result_t           out_q;
  logic              out_valid_q;

  logic [KeyW-1:0]   key_w;
  logic              accept;
  logic              head_we;
  logic [KeyW-1:0]   head_waddr;
  logic [VidxW-1:0]  head_wdata;
  logic              head_re;
  logic [VidxW-1:0]  head_rdata;
  logic              vert_we;
  logic [VidxW-1:0]  vert_waddr;
  vert_t             vert_wdata;
  logic              vert_re;
  logic [VidxW-1:0]  vert_raddr;
  vert_t             ent;
  vert_t             new_ent;
  vert_t             link_ent;
  logic [WideW-1:0]  total_ext;
  logic [WideW-1:0]  head_ext;
  logic [WideW-1:0]  link_ext;
  logic              head_ok;
  logic              link_go;
  logic              key_ok;
  logic              match;
  logic              full;
  logic [UvCountW-1:0] slots;
  logic [VidxW+12:0] out_idx_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  vdib_key #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .pos_i  (in_data_i.pos_index),
    .key_o  (key_w)
  );

  vdib_ram #(
    .DATA_W(VidxW),
    .DEPTH (MAX_POSITIONS)
  ) u_head (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .re_i   (head_re),
    .raddr_i(key_w),
    .rdata_o(head_rdata)
  );

  vdib_ram #(
    .DATA_W($bits(vert_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vert (
    .clk_i  (clk_i),
    .we_i   (vert_we),
    .waddr_i(vert_waddr),
    .wdata_i(vert_wdata),
    .re_i   (vert_re),
    .raddr_i(vert_raddr),
    .rdata_o(ent)
  );

  // Compare chain pointers against the vertex count
  assign total_ext = {{VidxW{1'b0}}, total_q};
  assign head_ext  = {{CntW{1'b0}}, head_rdata};
  assign link_ext  = {{CntW{1'b0}}, ent.link};
  assign head_ok   = head_ext < total_ext;
  assign link_go   = ent.link_ok && (link_ext < total_ext);
  assign full      = (total_q == CntW'(MAX_VERTICES));

  // A head entry is stale unless the vertex it names carries this key
  assign key_ok = !first_q || (ent.key == key_w);

  assign slots = (uv_cnt_q > UvCountW'(UV_SLOTS)) ? UvCountW'(UV_SLOTS) : uv_cnt_q;

  // Tuple compare over the enabled texture slots
  always_comb begin
    match = (ent.pos == item_q.pos_index) && (ent.nrm == item_q.normal_index);
    for (int s = 0; s < UV_SLOTS; s++) begin
      if ((UvCountW'(s) < slots) && (ent.uv[s] != uv_of(item_q, 3'(s)))) begin
        match = 1'b0;
      end
    end
  end

  // Build the appended entry and the relinked tail entry
  always_comb begin
    new_ent.key     = key_w;
    new_ent.pos     = item_q.pos_index;
    new_ent.nrm     = item_q.normal_index;
    for (int s = 0; s < UV_SLOTS; s++) begin
      new_ent.uv[s] = uv_of(item_q, 3'(s));
    end
    new_ent.link_ok = 1'b0;
    new_ent.link    = '0;
    link_ent         = last_ent_q;
    link_ent.link_ok = 1'b1;
    link_ent.link    = res_idx_q;
  end

  // Memory port control
  always_comb begin
    head_we    = (state_q == S_CLR) || ((state_q == S_APP) && !full && !have_last_q);
    head_waddr = (state_q == S_CLR) ? clr_q : key_w;
    head_wdata = (state_q == S_CLR) ? '0 : total_q[VidxW-1:0];
    head_re    = (state_q == S_HREQ);
    vert_re    = ((state_q == S_HEAD) && head_ok) ||
                 ((state_q == S_CMP) && key_ok && !match && link_go);
    vert_raddr = (state_q == S_HEAD) ? head_rdata : ent.link;
    vert_we    = ((state_q == S_APP) && !full) || (state_q == S_LINK);
    vert_waddr = (state_q == S_LINK) ? last_q : total_q[VidxW-1:0];
    vert_wdata = (state_q == S_LINK) ? link_ent : new_ent;
  end

  assign out_idx_ext = {13'd0, res_idx_q};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      item_q        <= '0;
      total_q       <= '0;
      uv_cnt_q      <= '0;
      clr_q         <= '0;
      cur_q         <= '0;
      first_q       <= 1'b0;
      have_last_q   <= 1'b0;
      last_q        <= '0;
      last_ent_q    <= '0;
      res_idx_q     <= '0;
      res_created_q <= 1'b0;
      res_full_q    <= 1'b0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        uv_cnt_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == KeyW'(MAX_POSITIONS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            if (in_data_i.new_mesh) begin
              total_q <= '0;
            end
            state_q <= S_KEY;
          end
        end
        S_KEY:  state_q <= S_HREQ;
        S_HREQ: state_q <= S_HEAD;
        S_HEAD: begin
          first_q     <= 1'b1;
          have_last_q <= 1'b0;
          cur_q       <= head_rdata;
          state_q     <= head_ok ? S_CMP : S_APP;
        end
        S_CMP: begin
          priority if (!key_ok) begin
            state_q <= S_APP;
          end else if (match) begin
            res_idx_q     <= cur_q;
            res_created_q <= 1'b0;
            res_full_q    <= 1'b0;
            state_q       <= S_OUT;
          end else begin
            last_q      <= cur_q;
            last_ent_q  <= ent;
            have_last_q <= 1'b1;
            first_q     <= 1'b0;
            if (link_go) begin
              cur_q <= ent.link;
            end else begin
              state_q <= S_APP;
            end
          end
        end
        S_APP: begin
          if (full) begin
            res_idx_q     <= '0;
            res_created_q <= 1'b0;
            res_full_q    <= 1'b1;
            state_q       <= S_OUT;
          end else begin
            res_idx_q     <= total_q[VidxW-1:0];
            res_created_q <= 1'b1;
            res_full_q    <= 1'b0;
            total_q       <= total_q + 1'b1;
            state_q       <= have_last_q ? S_LINK : S_OUT;
          end
        end
        S_LINK: state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.vertex_index <= out_idx_ext[12:0];
            out_q.created      <= res_created_q;
            out_q.table_full   <= res_full_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.created && out_q.table_full))
    else $error("created and table_full raised together");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_one_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second corner taken while one is in flight");
`endif

endmodule

// ===== hw/rtl/vdib_ram.sv =====
module vdib_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vdib_key.sv =====
module vdib_key #(
  parameter int unsigned MAX_POSITIONS = vdib_pkg::MaxPositions
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [vdib_pkg::PosW-1:0]        pos_i,
  output logic [$clog2(MAX_POSITIONS)-1:0] key_o
);
  import vdib_pkg::*;

  localparam int unsigned KeyW  = $clog2(MAX_POSITIONS);
  localparam int unsigned MpC   = (MAX_POSITIONS > 4096) ? 4096 : MAX_POSITIONS;
  localparam int unsigned Recip = (1 << 24) / MAX_POSITIONS;

  logic [32:0]     prod;
  logic [8:0]      quot_q;
  logic [PosW-1:0] pos_q;
  logic            stage_q;
  logic [21:0]     qm;
  logic [12:0]     rem_raw;
  logic [12:0]     rem;
  logic [KeyW+12:0] rem_ext;
  logic [KeyW-1:0] key_q;

  // Estimate the quotient by reciprocal multiplication
  assign prod = {21'd0, pos_i} * 33'(Recip);

  // Remainder with one correction step
  assign qm      = {13'd0, quot_q} * 22'(MpC);
  assign rem_raw = {1'b0, pos_q} - qm[12:0];
  assign rem     = (rem_raw >= 13'(MpC)) ? rem_raw - 13'(MpC) : rem_raw;
  assign rem_ext = {{KeyW{1'b0}}, rem};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      quot_q  <= '0;
      pos_q   <= '0;
      key_q   <= '0;
    end else begin
      stage_q <= start_i;
      if (start_i) begin
        quot_q <= prod[32:24];
        pos_q  <= pos_i;
      end
      if (stage_q) begin
        key_q <= rem_ext[KeyW-1:0];
      end
    end
  end

  assign key_o = key_q;

endmodule

// ===== tb/vertex_dedup_index_builder_tb.sv =====
module vertex_dedup_index_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vdib_pkg::*;

  localparam int unsigned LimitCycles = 2_000_000;
  localparam int unsigned NumRandom   = 1800;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  item_t   in_data_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;
  logic    cfg_we_i = 1'b0;
  logic [UvCountW-1:0] cfg_wdata_i = '0;

  vertex_dedup_index_builder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the deduplication state
  bit                 head_used[MaxPositions];
  int unsigned        head_vtx[MaxPositions];
  bit                 link_used[MaxVertices];
  int unsigned        link_vtx[MaxVertices];
  logic [PosW-1:0]    vtx_pos[MaxVertices];
  logic [AttrW-1:0]   vtx_nrm[MaxVertices];
  logic [AttrW-1:0]   vtx_uv[MaxVertices][UvSlots];
  int unsigned        vtx_count;
  logic [UvCountW-1:0] uv_sets;

  result_t   expected_idx_q[$];
  int unsigned n_errors;
  int unsigned cycle_count;
  bit          hold_off_req;

  function automatic void corner_uvs(item_t it, output logic [AttrW-1:0] u[UvSlots]);
    u[0] = it.uv_index_0; u[1] = it.uv_index_1; u[2] = it.uv_index_2;
    u[3] = it.uv_index_3; u[4] = it.uv_index_4; u[5] = it.uv_index_5;
    u[6] = it.uv_index_6; u[7] = it.uv_index_7;
  endfunction

  // Resolve one corner to an output vertex, updating the shadow state
  function automatic result_t resolve_corner(item_t it);
    result_t r;
    logic [AttrW-1:0] u[UvSlots];
    int unsigned slots, key, v, last, steps;
    bit have_last, more, hit;
    r = '0;
    corner_uvs(it, u);
    slots = (uv_sets > UvSlots) ? UvSlots : uv_sets;
    key = it.pos_index % MaxPositions;
    have_last = 0;
    last = 0;
    if (it.new_mesh) begin
      foreach (head_used[i]) head_used[i] = 0;
      vtx_count = 0;
    end
    if (head_used[key]) begin
      more = 1;
      v = head_vtx[key];
      for (steps = 0; more && steps < MaxVertices && v < vtx_count; steps++) begin
        hit = (vtx_pos[v] == it.pos_index) && (vtx_nrm[v] == it.normal_index);
        for (int s = 0; s < slots; s++)
          if (vtx_uv[v][s] != u[s]) hit = 0;
        if (hit) begin
          r.vertex_index = v[OutIdxW-1:0];
          return r;
        end
        last = v;
        have_last = 1;
        more = link_used[v];
        v = link_vtx[v];
      end
    end
    if (vtx_count >= MaxVertices) begin
      r.table_full = 1'b1;
      return r;
    end
    v = vtx_count;
    vtx_pos[v] = it.pos_index;
    vtx_nrm[v] = it.normal_index;
    for (int s = 0; s < UvSlots; s++) vtx_uv[v][s] = u[s];
    link_used[v] = 0;
    link_vtx[v] = 0;
    if (have_last) begin
      link_vtx[last] = v;
      link_used[last] = 1;
    end else begin
      head_vtx[key] = v;
      head_used[key] = 1;
    end
    vtx_count = v + 1;
    r.vertex_index = v[OutIdxW-1:0];
    r.created = 1'b1;
    return r;
  endfunction

  function automatic item_t make_corner(bit nm, int unsigned pos, int unsigned nrm,
                                        int unsigned uvb);
    item_t it;
    it.new_mesh = nm;
    it.pos_index = PosW'(pos);
    it.normal_index = AttrW'(nrm);
    it.uv_index_0 = AttrW'(uvb);
    it.uv_index_1 = AttrW'(uvb + 1);
    it.uv_index_2 = AttrW'(uvb + 2);
    it.uv_index_3 = AttrW'(uvb + 3);
    it.uv_index_4 = AttrW'(uvb + 4);
    it.uv_index_5 = AttrW'(uvb + 5);
    it.uv_index_6 = AttrW'(uvb + 6);
    it.uv_index_7 = AttrW'(uvb + 7);
    return it;
  endfunction

  // Offer one corner after an optional idle gap, wait for the transaction
  task automatic send_corner(item_t it, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_idx_q.push_back(resolve_corner(it));
  endtask

  task automatic drain_and_config(logic [UvCountW-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_idx_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    uv_sets = val;
  endtask

  // Directed corners; expected typed where obvious
  typedef struct {
    item_t   it;
    bit      known;
    result_t res;
  } dir_row_t;

  // Check results against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_idx_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data_o);
        n_errors++;
      end else begin
        result_t e;
        e = expected_idx_q.pop_front();
        if (out_data_o.vertex_index !== e.vertex_index ||
            out_data_o.created !== e.created ||
            out_data_o.table_full !== e.table_full) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data_o);
          n_errors++;
        end
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    int unsigned stall_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else if (hold_off_req) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Guard against a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("vertex_dedup_index_builder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    item_t it;
    int unsigned burst, npos;
    n_errors = 0;
    cycle_count = 0;
    hold_off_req = 0;
    vtx_count = 0;
    uv_sets = '0;
    foreach (head_used[i]) head_used[i] = 0;
    foreach (link_used[i]) link_used[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First corner after reset creates vertex 0
    row.it = make_corner(1, 0, 0, 0);             row.known = 1;
    row.res = '{vertex_index: 0, created: 1, table_full: 0}; rows.push_back(row);
    row.it = make_corner(0, 0, 0, 0);             row.known = 1;
    row.res = '{vertex_index: 0, created: 0, table_full: 0}; rows.push_back(row);
    row.it = make_corner(0, 4095, 16'hFFFF, 16'hFFF8); row.known = 1;
    row.res = '{vertex_index: 1, created: 1, table_full: 0}; rows.push_back(row);
    row.known = 0;
    // Same position, other normal: chain append behind existing entry
    row.it = make_corner(0, 0, 16'hFFFF, 0);      rows.push_back(row);
    row.it = make_corner(0, 0, 5, 0);             rows.push_back(row);
    row.it = make_corner(0, 0, 16'hFFFF, 0);      rows.push_back(row);
    row.it = make_corner(0, 0, 5, 0);             rows.push_back(row);
    // Ignored texture slots: differ only in uvs, slot count zero
    row.it = make_corner(0, 4095, 16'hFFFF, 16'h1234); rows.push_back(row);
    row.it = make_corner(1, 7, 7, 7);             rows.push_back(row);
    row.it = make_corner(0, 7, 7, 99);            rows.push_back(row);

    for (int i = 0; i < rows.size(); i++) begin
      send_corner(rows[i].it, $urandom_range(0, 3));
      if (rows[i].known && expected_idx_q[$] != rows[i].res) begin
        $display("%0t: directed row %0d expected %p actual %p", $realtime, i,
                 rows[i].res, expected_idx_q[$]);
        n_errors++;
      end
    end

    // Slot count above the limit and at the extreme, uvs now compared
    drain_and_config(4'd15);
    send_corner(make_corner(0, 7, 7, 7), 0);
    send_corner(make_corner(0, 7, 7, 8), 0);
    send_corner(make_corner(0, 7, 7, 7), 0);
    drain_and_config(4'd8);
    send_corner(make_corner(0, 7, 7, 8), 0);

    // Long hold-off on the receiver while corners keep coming
    fork
      begin
        hold_off_req = 1;
        repeat (200) @(posedge clk_i);
        hold_off_req = 0;
      end
      for (int i = 0; i < 20; i++)
        send_corner(make_corner(0, i, i, i), 0);
    join

    // Random corners in bursts, changing slot count between phases
    npos = 16;
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_config(ph == 5 ? 4'd0 : 4'($urandom_range(0, 15)));
      npos = (ph % 2) ? 4096 : 24;
      for (int n = 0; n < NumRandom / 6; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++, n++) begin
          it = make_corner($urandom_range(0, 150) == 0,
                           npos == 4096 ? $urandom : $urandom_range(0, npos - 1),
                           $urandom_range(0, 3), 0);
          it.uv_index_0 = AttrW'($urandom_range(0, 2));
          it.uv_index_1 = AttrW'($urandom_range(0, 1));
          it.uv_index_2 = AttrW'($urandom_range(0, 1));
          it.uv_index_3 = AttrW'(($urandom_range(0, 9) == 0) ? $urandom : 0);
          it.uv_index_4 = AttrW'($urandom_range(0, 1));
          it.uv_index_5 = AttrW'(($urandom_range(0, 9) == 0) ? $urandom : 0);
          it.uv_index_6 = AttrW'($urandom);
          it.uv_index_7 = AttrW'($urandom);
          if ($urandom_range(0, 20) == 0) it.normal_index = AttrW'($urandom);
          send_corner(it, (b == 0) ? $urandom_range(0, 12) : $urandom_range(0, 1));
        end
      end
    end

    // Fresh mesh restarts numbering, then the same corner matches
    drain_and_config(4'd0);
    send_corner(make_corner(1, 4095, 1, 0), 0);
    send_corner(make_corner(0, 4095, 1, 0), $urandom_range(0, 3));
    in_valid_i <= 1'b0;

    while (expected_idx_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("vertex_dedup_index_builder_tb OK");
    end else begin
      $display("vertex_dedup_index_builder_tb NOT OK");
    end
    $finish;
  end

endmodule
